// ===== rtl/bst_pkg.sv =====
// ---------------------------------------------------------------------------
// bst_pkg
// Shared types, token codes and character constants for the tokenizer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bst_pkg;

  localparam int TYPE_W = 4;
  localparam int LEN_W  = 7;
  localparam int CHAR_W = 8;
  localparam int KP_W   = 3;

  // token type codes
  localparam logic [TYPE_W-1:0] TT_EOF     = 4'd0;
  localparam logic [TYPE_W-1:0] TT_LET     = 4'd1;
  localparam logic [TYPE_W-1:0] TT_IDENT   = 4'd2;
  localparam logic [TYPE_W-1:0] TT_NUMBER  = 4'd3;
  localparam logic [TYPE_W-1:0] TT_EQ      = 4'd4;
  localparam logic [TYPE_W-1:0] TT_SEMI    = 4'd5;
  localparam logic [TYPE_W-1:0] TT_PLUS    = 4'd6;
  localparam logic [TYPE_W-1:0] TT_MINUS   = 4'd7;
  localparam logic [TYPE_W-1:0] TT_STAR    = 4'd8;
  localparam logic [TYPE_W-1:0] TT_SLASH   = 4'd9;
  localparam logic [TYPE_W-1:0] TT_LPAREN  = 4'd10;
  localparam logic [TYPE_W-1:0] TT_RPAREN  = 4'd11;
  localparam logic [TYPE_W-1:0] TT_DOT     = 4'd12;
  localparam logic [TYPE_W-1:0] TT_UNKNOWN = 4'd13;

  // scan modes
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_IDENT  = 2'd1;
  localparam logic [1:0] MODE_NUMBER = 2'd2;

  // keyword tracker: 0..3 chars matched, DEAD = mismatch or extra char seen
  localparam logic [KP_W-1:0] KP_FULL = 3'd3;
  localparam logic [KP_W-1:0] KP_DEAD = 3'd4;

  // character constants
  localparam logic [CHAR_W-1:0] CH_EQ     = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_L      = 8'h6C;
  localparam logic [CHAR_W-1:0] CH_E      = 8'h65;
  localparam logic [CHAR_W-1:0] CH_T      = 8'h74;

  typedef struct packed {
    logic [TYPE_W-1:0] token_type;
    logic [LEN_W-1:0]  token_length;
    logic [CHAR_W-1:0] single_char;
    logic              too_long;
    logic              last;
  } token_t;

  // up to two tokens caused by one item
  typedef struct packed {
    token_t tok0;
    token_t tok1;
    logic   two;
  } tok_pair_t;

  typedef struct packed {
    logic              is_space;
    logic              is_alpha;
    logic              is_digit;
    logic              is_under;
    logic [TYPE_W-1:0] punct_type;
  } char_class_t;

  // keyword spelling, one char per matched position
  function automatic logic [CHAR_W-1:0] kw_char(input logic [KP_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    case (idx)
      3'd0:    c = CH_L;
      3'd1:    c = CH_E;
      3'd2:    c = CH_T;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bst_ifs.sv =====
// ---------------------------------------------------------------------------
// bst_ifs
// Valid/ready channels: character items in, token items out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bst_in_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [bst_pkg::CHAR_W-1:0] ch;

  modport source (output valid, output kind, output ch, input ready);
  modport sink   (input valid, input kind, input ch, output ready);
endinterface

interface bst_out_if;
  logic                       valid;
  logic                       ready;
  logic [bst_pkg::TYPE_W-1:0] token_type;
  logic [bst_pkg::LEN_W-1:0]  token_length;
  logic [bst_pkg::CHAR_W-1:0] single_char;
  logic                       too_long;
  logic                       last;

  modport source (output valid, output token_type, output token_length,
                  output single_char, output too_long, output last, input ready);
  modport sink   (input valid, input token_type, input token_length,
                  input single_char, input too_long, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/bst_char_class.sv =====
// ---------------------------------------------------------------------------
// bst_char_class
// Character class decode and punctuation lookup for one byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bst_char_class (
  input  logic [bst_pkg::CHAR_W-1:0] ch,
  output bst_pkg::char_class_t       cls
);

  always_comb begin
    cls.is_space = (ch == bst_pkg::CH_SPACE) ||
                   (ch inside {[bst_pkg::CH_TAB:bst_pkg::CH_CR]});
    cls.is_alpha = (ch inside {[8'h41:8'h5A], [8'h61:8'h7A]});
    cls.is_digit = (ch inside {[8'h30:8'h39]});
    cls.is_under = (ch == bst_pkg::CH_UNDER);
    case (ch)
      bst_pkg::CH_EQ:     cls.punct_type = bst_pkg::TT_EQ;
      bst_pkg::CH_SEMI:   cls.punct_type = bst_pkg::TT_SEMI;
      bst_pkg::CH_PLUS:   cls.punct_type = bst_pkg::TT_PLUS;
      bst_pkg::CH_MINUS:  cls.punct_type = bst_pkg::TT_MINUS;
      bst_pkg::CH_STAR:   cls.punct_type = bst_pkg::TT_STAR;
      bst_pkg::CH_SLASH:  cls.punct_type = bst_pkg::TT_SLASH;
      bst_pkg::CH_LPAREN: cls.punct_type = bst_pkg::TT_LPAREN;
      bst_pkg::CH_RPAREN: cls.punct_type = bst_pkg::TT_RPAREN;
      bst_pkg::CH_DOT:    cls.punct_type = bst_pkg::TT_DOT;
      default:            cls.punct_type = bst_pkg::TT_UNKNOWN;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/bst_scanner.sv =====
// ---------------------------------------------------------------------------
// bst_scanner
// Scan state and token build: one item per cycle while accept is high, zero to two tokens out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bst_scanner #(
  parameter int MAX_TOKEN_LEN = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic                       kind,
  input  logic [bst_pkg::CHAR_W-1:0] ch,
  input  bst_pkg::char_class_t       cls,
  output logic                       pair_valid,
  output bst_pkg::tok_pair_t         pair
);

  localparam logic [bst_pkg::LEN_W-1:0] MAX_LEN = bst_pkg::LEN_W'(MAX_TOKEN_LEN);
  localparam logic [bst_pkg::LEN_W-1:0] KW_LEN  = 7'd3;

  logic [1:0]               mode, mode_next;
  logic [bst_pkg::LEN_W-1:0] len, len_next;
  logic [bst_pkg::KP_W-1:0]  kp, kp_next;
  logic                     ovf, ovf_next;

  logic [1:0]     mode_eff;
  logic           ident_cont;
  logic           extend;
  logic           has_flush;
  logic           has_second;
  bst_pkg::token_t flush_tok;
  bst_pkg::token_t second_tok;

  // keyword prefix tracker step
  function automatic logic [bst_pkg::KP_W-1:0] kw_step(
    input logic [bst_pkg::KP_W-1:0]  cur,
    input logic [bst_pkg::CHAR_W-1:0] c
  );
    logic [bst_pkg::KP_W-1:0] r;
    if (cur < bst_pkg::KP_FULL && c == bst_pkg::kw_char(cur)) begin
      r = cur + 3'd1;
    end else begin
      r = bst_pkg::KP_DEAD;
    end
    return r;
  endfunction

  always_comb begin
    mode_eff = (mode == bst_pkg::MODE_IDENT || mode == bst_pkg::MODE_NUMBER) ?
               mode : bst_pkg::MODE_IDLE;
    ident_cont = cls.is_alpha || cls.is_digit || cls.is_under;
    extend = !kind &&
             ((mode_eff == bst_pkg::MODE_IDENT && ident_cont) ||
              (mode_eff == bst_pkg::MODE_NUMBER && cls.is_digit));
    has_flush = (mode_eff != bst_pkg::MODE_IDLE) && !extend;

    flush_tok = '0;
    if (mode_eff == bst_pkg::MODE_IDENT) begin
      flush_tok.token_type = (kp == bst_pkg::KP_FULL && len == KW_LEN && !ovf) ?
                             bst_pkg::TT_LET : bst_pkg::TT_IDENT;
    end else begin
      flush_tok.token_type = bst_pkg::TT_NUMBER;
    end
    flush_tok.token_length = len;
    flush_tok.too_long     = ovf;

    second_tok = '0;
    has_second = 1'b0;
    if (kind) begin
      second_tok.token_type = bst_pkg::TT_EOF;
      has_second = 1'b1;
    end else if (!extend && !cls.is_space && !cls.is_alpha && !cls.is_under &&
                 !cls.is_digit) begin
      second_tok.token_type   = cls.punct_type;
      second_tok.token_length = 7'd1;
      second_tok.single_char  = ch;
      has_second = 1'b1;
    end

    mode_next = mode_eff;
    len_next  = len;
    kp_next   = kp;
    ovf_next  = ovf;
    if (kind) begin
      mode_next = bst_pkg::MODE_IDLE;
      len_next  = '0;
      kp_next   = '0;
      ovf_next  = 1'b0;
    end else if (extend) begin
      if (len < MAX_LEN) begin
        len_next = len + 7'd1;
      end else begin
        ovf_next = 1'b1;
      end
      if (mode_eff == bst_pkg::MODE_IDENT) begin
        kp_next = kw_step(kp, ch);
      end
    end else begin
      mode_next = bst_pkg::MODE_IDLE;
      len_next  = '0;
      kp_next   = '0;
      ovf_next  = 1'b0;
      if (cls.is_alpha || cls.is_under) begin
        mode_next = bst_pkg::MODE_IDENT;
        len_next  = 7'd1;
        kp_next   = kw_step('0, ch);
      end else if (cls.is_digit) begin
        mode_next = bst_pkg::MODE_NUMBER;
        len_next  = 7'd1;
      end
    end

    // pending token goes first, the new one after it
    pair = '0;
    if (has_flush) begin
      pair.tok0 = flush_tok;
      pair.tok1 = second_tok;
      pair.two  = has_second;
    end else begin
      pair.tok0 = second_tok;
    end
    if (pair.two) begin
      pair.tok1.last = 1'b1;
    end else begin
      pair.tok0.last = 1'b1;
    end
    pair_valid = accept && (has_flush || has_second);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= bst_pkg::MODE_IDLE;
      len  <= '0;
      kp   <= '0;
      ovf  <= 1'b0;
    end else if (accept) begin
      mode <= mode_next;
      len  <= len_next;
      kp   <= kp_next;
      ovf  <= ovf_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bst_result_queue.sv =====
// ---------------------------------------------------------------------------
// bst_result_queue
// Two-entry queue of token pairs; hands out one token per cycle while out_ready is high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bst_result_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bst_pkg::tok_pair_t push_pair,
  output logic               full,
  output logic               out_valid,
  input  logic               out_ready,
  output bst_pkg::token_t    out_tok
);

  bst_pkg::tok_pair_t q [2];
  logic       head, tail, idx;
  logic [1:0] count, count_next;
  logic       pop_tok, pair_done;

  always_comb begin
    out_valid = (count != 2'd0);
    out_tok   = idx ? q[head].tok1 : q[head].tok0;
    pop_tok   = out_valid && out_ready;
    pair_done = pop_tok && (idx || !q[head].two);
    full      = (count == 2'd2);
    count_next = count + {1'b0, push} - {1'b0, pair_done};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[tail] <= push_pair;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      tail  <= 1'b0;
      idx   <= 1'b0;
      count <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        tail <= ~tail;
      end
      if (pair_done) begin
        head <= ~head;
        idx  <= 1'b0;
      end else if (pop_tok) begin
        idx <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/byte_stream_tokenizer_core.sv =====
// ---------------------------------------------------------------------------
// byte_stream_tokenizer_core
// Character-at-a-time lexical scanner: identifiers, numbers, "let", punctuation.
// ---------------------------------------------------------------------------
// One character item (or end-of-input mark) is taken per clock while chars
// is ready; its class decode and scan-state update finish in the same cycle
// and the zero, one or two tokens it causes land in a two-entry queue of
// token pairs that feeds the tokens channel one token per cycle while
// tokens.ready is high. The input side stays ready whenever the queue has a
// free pair slot, so items that produce at most one token flow at one per
// cycle; an item ending an identifier or number with punctuation, an unknown
// character or end of input (two tokens) sends both through the single
// output port, which then sets the rate. Identifier and number lengths
// saturate at MAX_TOKEN_LEN with too_long set; the token text is not kept.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module byte_stream_tokenizer_core #(
  parameter int MAX_TOKEN_LEN = 64   // 4..127
) (
  input  logic      clk,
  input  logic      rst,
  bst_in_if.sink    chars,
  bst_out_if.source tokens
);

  bst_pkg::char_class_t cls;
  bst_pkg::tok_pair_t   pair;
  bst_pkg::token_t      out_tok;
  logic                 pair_valid;
  logic                 full;
  logic                 accept;

  // ready only depends on queue occupancy, never on the output side
  assign chars.ready = !full;
  assign accept      = chars.valid && chars.ready;

  bst_char_class u_class (
    .ch  (chars.ch),
    .cls (cls)
  );

  bst_scanner #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_scanner (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .kind       (chars.kind),
    .ch         (chars.ch),
    .cls        (cls),
    .pair_valid (pair_valid),
    .pair       (pair)
  );

  // items that cause no token (whitespace, continuing a token) are not queued
  bst_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (pair_valid),
    .push_pair (pair),
    .full      (full),
    .out_valid (tokens.valid),
    .out_ready (tokens.ready),
    .out_tok   (out_tok)
  );

  assign tokens.token_type   = out_tok.token_type;
  assign tokens.token_length = out_tok.token_length;
  assign tokens.single_char  = out_tok.single_char;
  assign tokens.too_long     = out_tok.too_long;
  assign tokens.last         = out_tok.last;

endmodule

`default_nettype wire

// ===== rtl/bst_checker.sv =====
// ---------------------------------------------------------------------------
// bst_checker
// Port-level assertions for the tokenizer, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bst_checker #(
  parameter int MAX_TOKEN_LEN = 64
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [bst_pkg::TYPE_W-1:0] token_type,
  input logic [bst_pkg::LEN_W-1:0]  token_length,
  input logic [bst_pkg::CHAR_W-1:0] single_char,
  input logic                       too_long,
  input logic                       last
);

  localparam logic [bst_pkg::LEN_W-1:0] MAX_LEN = bst_pkg::LEN_W'(MAX_TOKEN_LEN);

  // stalled token holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable(token_type) && $stable(token_length) && $stable(single_char) &&
      $stable(too_long) && $stable(last))
    else $error("token changed while stalled");

  // eof is always the closing token of its item, empty
  a_eof_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_type == bst_pkg::TT_EOF |->
      last && token_length == 7'd0 && single_char == 8'd0 && !too_long)
    else $error("malformed eof token");

  // punctuation and unknown tokens are one char and always close their item
  a_single_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_type >= bst_pkg::TT_EQ |->
      last && token_length == 7'd1 && !too_long)
    else $error("malformed single-character token");

  // overflow only on saturated identifiers or numbers
  a_too_long: assert property (@(posedge clk) disable iff (rst)
    out_valid && too_long |->
      token_length == MAX_LEN &&
      (token_type == bst_pkg::TT_IDENT || token_type == bst_pkg::TT_NUMBER))
    else $error("too_long on wrong token");

  // a full queue stays full until a token leaves
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    !in_ready && !(out_valid && out_ready) |=> !in_ready)
    else $error("input side freed without output progress");

endmodule

bind byte_stream_tokenizer_core bst_checker #(
  .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
) u_bst_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (chars.ready),
  .out_valid    (tokens.valid),
  .out_ready    (tokens.ready),
  .token_type   (tokens.token_type),
  .token_length (tokens.token_length),
  .single_char  (tokens.single_char),
  .too_long     (tokens.too_long),
  .last         (tokens.last)
);

`default_nettype wire
